>>> rtl/lvps_pkg.sv
// Constants for the longest well-formed bracket substring block.
// No dependencies; imported by longest_valid_paren_stack.
package lvps_pkg;

	// default string length limit
	localparam int MAX_LEN_DEF = 1024;

	// byte that counts as an open bracket, every other byte closes
	localparam logic [7:0] OPEN_BYTE = 8'h28;

	// width of the reported length and its saturation value
	localparam int BEST_W = 11;
	localparam logic [BEST_W-1:0] BEST_MAX = 11'd2047;

endpackage

>>> rtl/longest_valid_paren_stack.sv
// Longest well-formed bracket substring over a byte stream, position stack in RAM.
// Depends on lvps_pkg (rtl/lvps_pkg.sv).
//
//  channel | direction | handshake           | beat fields
//  --------+-----------+---------------------+--------------------------------
//  input   | in        | in_valid / in_stall | ch[7:0], last
//  output  | out       | out_valid/out_stall | best_length[10:0], done_res, too_long
//
// One byte per cycle unless out_stall holds it; each beat gives exactly one result.
// Stage 0 decides push or pop and issues the stack RAM write or read; stage 1 takes
// the registered top entry and updates the best length into the output register.
// The bottom (sentinel) entry lives in a register, so no clearing pass is needed.
// Reset and last restore position and depth; reset or last leaving stage 1 clears best.
// A stalled output holds stage 1, which holds the input through in_stall.

module longest_valid_paren_stack
	import lvps_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        ch,
	input  logic              last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BEST_W-1:0] best_length,
	output logic              done_res,
	output logic              too_long
);

	localparam int PW = $clog2(MAX_LEN + 1);   // position / tag width
	localparam int DW = $clog2(MAX_LEN + 2);   // stack depth width
	localparam int AW = $clog2(MAX_LEN + 1);   // RAM address width
	localparam int EW = (PW > BEST_W) ? PW : BEST_W;

	// stage 0 state
	logic [PW-1:0] position_q;
	logic [DW-1:0] depth_q;
	logic [PW-1:0] bottom_q;
	logic          overflow_q;

	// stack RAM, entries 1..MAX_LEN used
	logic [PW-1:0] stack_mem [MAX_LEN+1];

	// stage 1
	logic          valid_s1;
	logic          cmp_s1;
	logic          last_s1;
	logic          too_long_s1;
	logic [PW-1:0] tag_s1;
	logic          bot_sel_s1;
	logic [PW-1:0] bot_s1;
	logic [PW-1:0] rd_s1;

	// stage 2 / output
	logic [PW-1:0]     best_q;
	logic              out_valid_q;
	logic [BEST_W-1:0] best_length_q;
	logic              done_q;
	logic              too_long_q;

	logic          in_acc;
	logic          s1_adv;
	logic          in_range;
	logic          is_open;
	logic [PW-1:0] tag;
	logic          do_push;
	logic          do_base;
	logic          do_cmp;
	logic [DW-1:0] depth_m2;
	logic [AW-1:0] rd_addr;
	logic          rd_bot;
	logic [PW-1:0] top_s1;
	logic [PW-1:0] len_s1;
	logic [PW-1:0] best_nxt;
	logic [EW-1:0] best_ext;

	// handshake
	assign s1_adv   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_adv;
	assign in_acc   = in_valid && !in_stall;

	// stage 0 decode
	assign in_range = position_q < PW'(MAX_LEN);
	assign is_open  = ch == OPEN_BYTE;
	assign tag      = position_q + PW'(1);
	assign do_push  = in_range && is_open && (depth_q <= DW'(MAX_LEN));
	assign do_base  = in_range && !is_open && (depth_q == DW'(1));
	assign do_cmp   = in_range && !is_open && (depth_q > DW'(1));
	assign depth_m2 = depth_q - DW'(2);
	assign rd_addr  = depth_m2[AW-1:0];
	assign rd_bot   = depth_q == DW'(2);

	// stack control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			depth_q    <= DW'(1);
			bottom_q   <= '0;
			overflow_q <= 1'b0;
		end else if (in_acc) begin
			if (last) begin
				position_q <= '0;
				depth_q    <= DW'(1);
				bottom_q   <= '0;
				overflow_q <= 1'b0;
			end else if (!in_range) begin
				overflow_q <= 1'b1;
			end else begin
				position_q <= tag;
				if (do_push)
					depth_q <= depth_q + DW'(1);
				else if (do_cmp)
					depth_q <= depth_q - DW'(1);
				if (do_base)
					bottom_q <= tag;
			end
		end
	end

	// stack RAM: push writes, pop reads the new top (registered)
	always_ff @(posedge clk) begin
		if (in_acc && do_push)
			stack_mem[depth_q[AW-1:0]] <= tag;
		if (in_acc && do_cmp)
			rd_s1 <= stack_mem[rd_addr];
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmp_s1      <= do_cmp;
			last_s1     <= last;
			too_long_s1 <= overflow_q || !in_range;
			tag_s1      <= tag;
			bot_sel_s1  <= rd_bot;
			bot_s1      <= bottom_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_acc)
			valid_s1 <= 1'b1;
		else if (s1_adv)
			valid_s1 <= 1'b0;
	end

	// best length update and saturation
	assign top_s1   = bot_sel_s1 ? bot_s1 : rd_s1;
	assign len_s1   = tag_s1 - top_s1;
	assign best_nxt = (cmp_s1 && (len_s1 > best_q)) ? len_s1 : best_q;
	assign best_ext = EW'(best_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= s1_adv || (out_valid_q && out_stall);
			if (s1_adv)
				best_q <= last_s1 ? '0 : best_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			best_length_q <= (best_ext > EW'(BEST_MAX)) ? BEST_MAX : best_ext[BEST_W-1:0];
			done_q        <= last_s1;
			too_long_q    <= too_long_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign best_length = best_length_q;
	assign done_res    = done_q;
	assign too_long    = too_long_q;

	// checks
	a_depth_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q != '0)
		else $error("stack depth reached zero");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		DW'(position_q) + DW'(1) >= depth_q)
		else $error("stack deeper than bytes seen");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled with room downstream");

	a_last_restores: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && last) |=> (position_q == '0 && depth_q == DW'(1) && !overflow_q))
		else $error("state not restored after last beat");

endmodule

>>> bench/longest_valid_paren_stack_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for longest_valid_paren_stack: random and directed byte strings,
// a built-in bracket predictor and a result scoreboard. Depends on lvps_pkg and the RTL.
module longest_valid_paren_stack_tb
	import lvps_pkg::*;
();

	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 250;
	localparam int TAIL_CYCLES = 20;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} byte_beat_t;

	typedef struct packed {
		logic [BEST_W-1:0] best;
		logic              done;
		logic              ovf;
	} bracket_result_t;

	// wait patterns for either side
	typedef enum int {PACE_FLAT, PACE_WIDE, PACE_LIGHT} pace_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [7:0]        ch = 8'h00;
	logic              last = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [BEST_W-1:0] best_length;
	logic              done_res;
	logic              too_long;

	byte_beat_t      beat_queue[$];
	bracket_result_t expected_results[$];

	// predictor state: positions held as index + 1, bottom entry stands for -1
	int str_pos;
	int tag_stack [0:MAX_LEN_DEF];
	int stack_depth;
	int best_run;
	bit seen_overflow;

	int    errors = 0;
	int    results_seen = 0;
	int    strings_done = 0;
	int    overflow_results = 0;
	int    peak_best = 0;
	int    cycle_count = 0;
	logic  in_took = 1'b0;
	logic  out_took = 1'b0;
	int    gap_left = 0;
	int    stall_left = 0;
	int    hold_left = 0;
	int    hold_idx = 0;
	int    hold_at [2] = '{100, 700};
	int    beats_sent = 0;
	pace_t tx_pace = PACE_WIDE;
	pace_t rx_pace = PACE_WIDE;

	longest_valid_paren_stack #(.MAX_LEN(MAX_LEN_DEF)) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.ch         (ch),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.best_length(best_length),
		.done_res   (done_res),
		.too_long   (too_long)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_bracket_state();
		str_pos = 0;
		tag_stack[0] = 0;
		stack_depth = 1;
		best_run = 0;
		seen_overflow = 1'b0;
	endfunction

	// one byte through the position stack; returns the running best for it
	function automatic bracket_result_t advance_bracket_state(input byte_beat_t b);
		bracket_result_t r;
		int tag;
		int run;
		if (str_pos >= MAX_LEN_DEF) begin
			seen_overflow = 1'b1;
		end else begin
			tag = str_pos + 1;
			if (b.ch == OPEN_BYTE) begin
				if (stack_depth <= MAX_LEN_DEF) begin
					tag_stack[stack_depth] = tag;
					stack_depth++;
				end
			end else begin
				if (stack_depth > 0)
					stack_depth--;
				if (stack_depth == 0) begin
					tag_stack[0] = tag;
					stack_depth = 1;
				end else begin
					run = tag - tag_stack[stack_depth - 1];
					if (run > best_run)
						best_run = run;
				end
			end
			str_pos++;
		end
		r.best = (best_run > int'(BEST_MAX)) ? BEST_MAX : BEST_W'(best_run);
		r.done = b.last;
		r.ovf = seen_overflow;
		if (b.last)
			clear_bracket_state();
		return r;
	endfunction

	function automatic int draw_wait(input pace_t p);
		case (p)
			PACE_FLAT: return 0;
			PACE_WIDE: return $urandom_range(0, 12);
			default:   return $urandom_range(0, 2);
		endcase
	endfunction

	function automatic logic [7:0] close_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == OPEN_BYTE);
		return b;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("mismatch at result %0d: %s got %0d expected %0d",
			results_seen, what, got, want);
	endtask

	task automatic add_beat(input logic [7:0] c, input logic l);
		byte_beat_t b;
		b.ch = c;
		b.last = l;
		beat_queue = {beat_queue, b};
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_beat(s[i], i == s.len() - 1);
	endtask

	// mostly balanced bracket walks; noise_pct of the bytes are random instead
	task automatic add_random_string(input int len, input int noise_pct, input bit ends);
		int open_cnt;
		int remaining;
		logic [7:0] c;
		open_cnt = 0;
		for (int i = 0; i < len; i++) begin
			remaining = len - i;
			if ($urandom_range(0, 99) < noise_pct)
				c = $urandom_range(0, 1) ? OPEN_BYTE : close_byte();
			else if (open_cnt > 0 && open_cnt >= remaining - 1)
				c = close_byte();
			else if (open_cnt == 0)
				c = OPEN_BYTE;
			else
				c = $urandom_range(0, 1) ? OPEN_BYTE : close_byte();
			if (c == OPEN_BYTE)
				open_cnt++;
			else if (open_cnt > 0)
				open_cnt--;
			add_beat(c, ends && (i == len - 1));
		end
	endtask

	task automatic add_random_strings(input int item_goal);
		int count;
		int len;
		count = 0;
		while (count < item_goal) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
			add_random_string(len, ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(0, 15), 1'b1);
			count += len;
		end
	endtask

	// input driver: new beat at the falling edge once the previous one was taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_took)) begin
			if (beat_queue.size() == 0) begin
				in_valid <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else begin
				{ch, last} <= beat_queue.pop_front();
				in_valid <= 1'b1;
				beats_sent++;
				if (beats_sent % 64 == 0)
					tx_pace = pace_t'($urandom_range(0, 2));
				gap_left = draw_wait(tx_pace);
			end
		end
	end

	// long receiver hold-offs that fill the pipe, counted apart from per-beat waits
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
			end else if (hold_idx < 2 && results_seen >= hold_at[hold_idx]) begin
				hold_left <= HOLD_CYCLES;
				hold_idx <= hold_idx + 1;
			end
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_took) begin
				if (results_seen % 64 == 0)
					rx_pace = pace_t'($urandom_range(0, 2));
				stall_left = draw_wait(rx_pace);
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// monitor: predict on every input beat, check every output beat
	always @(posedge clk) begin
		bracket_result_t want;
		if (arst_n) begin
			in_took <= in_valid && !in_stall;
			out_took <= out_valid && !out_stall;
			if (in_valid && !in_stall)
				expected_results = {expected_results, advance_bracket_state({ch, last})};
			if (out_valid && !out_stall) begin
				results_seen++;
				if (done_res)
					strings_done++;
				if (too_long)
					overflow_results++;
				if (int'(best_length) > peak_best)
					peak_best = int'(best_length);
				if (expected_results.size() == 0) begin
					report_mismatch("beat with nothing pending, best_length",
						int'(best_length), 0);
				end else begin
					want = expected_results.pop_front();
					if (best_length !== want.best)
						report_mismatch("best_length", int'(best_length), int'(want.best));
					if (done_res !== want.done)
						report_mismatch("done_res", int'(done_res), int'(want.done));
					if (too_long !== want.ovf)
						report_mismatch("too_long", int'(too_long), int'(want.ovf));
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles, %0d results outstanding",
				cycle_count, expected_results.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		clear_bracket_state();

		// directed: single bytes, classic strings, bytes next to or one bit off the open code
		add_text("(");
		add_text(")");
		add_beat(8'h00, 1'b1);
		add_beat(8'hFF, 1'b1);
		add_text("()");
		add_text(")()())");
		add_text("()(())");
		add_beat(OPEN_BYTE, 1'b0);
		add_beat(8'hA8, 1'b0);
		add_beat(OPEN_BYTE, 1'b0);
		add_beat(8'h27, 1'b0);
		add_beat(OPEN_BYTE, 1'b0);
		add_beat(8'h29, 1'b1);

		add_random_strings(30);

		// full-length balanced string: best reaches the limit, then bytes past it
		add_random_string(MAX_LEN_DEF, 0, 1'b0);
		add_beat(OPEN_BYTE, 1'b0);
		add_beat(close_byte(), 1'b0);
		add_beat(OPEN_BYTE, 1'b1);

		add_random_strings(30);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (beat_queue.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d strings over %0d bytes checked, including one run past the limit",
			strings_done, results_seen);
		$display("%0d results flagged too long, peak length %0d",
			overflow_results, peak_best);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
